/* sv/lhc_pkg.sv */
// Shared types, codes and constants for the LFU hash cache.
`timescale 1ns / 1ps

package lhc_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 11;
    localparam int UNIT_W    = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] REQ_PUT = 2'd0;
    localparam logic [1:0] REQ_GET = 2'd1;
    localparam logic [1:0] REQ_HAS = 2'd2;

    typedef enum logic [1:0] {
        OP_MOD = 2'd0,
        OP_EQ  = 2'd1,
        OP_LT  = 2'd2,
        OP_INC = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
    } t_unit_req;

    typedef struct packed {
        logic [UNIT_W-1:0] res;
        logic              flag;
    } t_unit_rsp;

    typedef struct packed {
        logic [1:0]              req_type;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] store_value;
    } t_in_item;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
    } t_out_item;

endpackage

/* sv/lfu_hash_cache.sv */
// Top level: LFU hash cache sequencer with key, data and use-count RAMs.
// Get/test: hash, fold, then probe read/check per slot from the hash slot, then reply.
// Put: hash, fold, a probe read per slot, an evict scan of all slots if needed, then write.
// One transaction at a time: the next is accepted once the last has returned to S_IDLE;
//   a reply held off by i_out_stall keeps the sequencer waiting in S_REPLY.
// Reset: synchronous active low, clears control and slot-occupied bits.
`timescale 1ns / 1ps

module lfu_hash_cache #(
    parameter int SLOTS = lhc_pkg::SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lhc_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lhc_pkg::t_out_item o_out_data
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int RCP_SH = lhc_pkg::SUM_W + IDX_W + 1;
    localparam int PROD_W = lhc_pkg::SUM_W + RCP_SH;
    localparam logic [RCP_SH-1:0] RCP = RCP_SH'(((1 << RCP_SH) + SLOTS - 1) / SLOTS);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b0_0000_0001,
        S_HASH      = 9'b0_0000_0010,
        S_FOLD      = 9'b0_0000_0100,
        S_PROBE_RD  = 9'b0_0000_1000,
        S_PROBE_CHK = 9'b0_0001_0000,
        S_EVICT_RD  = 9'b0_0010_0000,
        S_EVICT_CHK = 9'b0_0100_0000,
        S_WRITE     = 9'b0_1000_0000,
        S_REPLY     = 9'b1_0000_0000
    } t_state;

    function automatic logic [lhc_pkg::KEY_W-1:0] canon_key(input logic [lhc_pkg::KEY_W-1:0] k);
        logic [lhc_pkg::KEY_W-1:0] r;
        logic                      alive;
        r     = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++) begin
            alive = alive & (k[8*b +: 8] != 8'd0);
            if (alive) begin
                r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [lhc_pkg::SUM_W-1:0] byte_sum(input logic [lhc_pkg::KEY_W-1:0] k);
        logic [lhc_pkg::SUM_W-1:0] s;
        s = '0;
        for (int b = 0; b < 8; b++) begin
            s = s + lhc_pkg::SUM_W'(k[8*b +: 8]);
        end
        return s;
    endfunction

    t_state                          r_state, n_state;
    logic [SLOTS-1:0]                r_used, n_used;
    logic                            r_out_valid, n_out_valid;
    lhc_pkg::t_out_item              r_out, n_out;
    logic [1:0]                      r_req, n_req;
    logic [lhc_pkg::KEY_W-1:0]       r_key, n_key;
    logic [lhc_pkg::VAL_W-1:0]       r_val, n_val;
    logic [lhc_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic [lhc_pkg::SUM_W-1:0]       r_quo, n_quo;
    logic [IDX_W-1:0]                r_idx, n_idx;
    logic [IDX_W-1:0]                r_slot, n_slot;
    logic [lhc_pkg::CNT_W-1:0]       r_best_cnt, n_best_cnt;
    logic                            r_found, n_found;
    logic [lhc_pkg::VAL_W-1:0]       r_data, n_data;
    logic [lhc_pkg::CNT_W-1:0]       r_cnt, n_cnt;

    lhc_pkg::t_unit_req              u_req;
    lhc_pkg::t_unit_rsp              u_rsp;

    logic [IDX_W-1:0]                mem_addr;
    logic                            tbl_we;
    logic                            cnt_we;
    logic [lhc_pkg::CNT_W-1:0]       cnt_wdata;
    logic [lhc_pkg::KEY_W-1:0]       q_key;
    logic [lhc_pkg::VAL_W-1:0]       q_data;
    logic [lhc_pkg::CNT_W-1:0]       q_cnt;
    logic [lhc_pkg::CNT_W-1:0]       cur_cnt;
    logic [lhc_pkg::KEY_W-1:0]       in_key;
    logic [PROD_W-1:0]               hash_prod;
    logic [lhc_pkg::SUM_W-1:0]       quo_prod;
    logic                            accept;
    logic                            out_load;

    lhc_unit u_unit (
        .i_req (u_req),
        .o_rsp (u_rsp)
    );

    lhc_ram #(.WIDTH(lhc_pkg::KEY_W), .DEPTH(SLOTS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_addr  (mem_addr),
        .i_wdata (r_key),
        .o_rdata (q_key)
    );

    lhc_ram #(.WIDTH(lhc_pkg::VAL_W), .DEPTH(SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_addr  (mem_addr),
        .i_wdata (r_val),
        .o_rdata (q_data)
    );

    lhc_ram #(.WIDTH(lhc_pkg::CNT_W), .DEPTH(SLOTS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_addr  (mem_addr),
        .i_wdata (cnt_wdata),
        .o_rdata (q_cnt)
    );

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign out_load  = !r_out_valid || !i_out_stall;
    assign in_key    = canon_key(i_in_data.key);
    assign cur_cnt   = r_used[r_idx] ? q_cnt : '0;
    assign hash_prod = PROD_W'(r_sum) * PROD_W'(RCP);
    assign quo_prod  = lhc_pkg::SUM_W'(r_quo * lhc_pkg::SUM_W'(SLOTS));

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_req       = r_req;
        n_key       = r_key;
        n_val       = r_val;
        n_sum       = r_sum;
        n_quo       = r_quo;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_best_cnt  = r_best_cnt;
        n_found     = r_found;
        n_data      = r_data;
        n_cnt       = r_cnt;
        mem_addr    = r_idx;
        tbl_we      = 1'b0;
        cnt_we      = 1'b0;
        cnt_wdata   = '0;
        u_req.op    = lhc_pkg::OP_EQ;
        u_req.a     = '0;
        u_req.b     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_in_data.req_type;
                    n_key = in_key;
                    n_val = i_in_data.store_value;
                    n_sum = byte_sum(in_key);
                    unique case (i_in_data.req_type) inside
                        lhc_pkg::REQ_PUT, lhc_pkg::REQ_GET, lhc_pkg::REQ_HAS: begin
                            n_state = S_HASH;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HASH: begin
                n_quo   = lhc_pkg::SUM_W'(hash_prod >> RCP_SH);
                n_state = S_FOLD;
            end
            S_FOLD: begin
                u_req.op = lhc_pkg::OP_MOD;
                u_req.a  = lhc_pkg::UNIT_W'(r_sum);
                u_req.b  = lhc_pkg::UNIT_W'(quo_prod);
                n_idx    = u_rsp.res[IDX_W-1:0];
                n_state  = S_PROBE_RD;
            end
            S_PROBE_RD: begin
                if (r_req == lhc_pkg::REQ_PUT) begin
                    if (!r_used[r_idx]) begin
                        n_slot  = r_idx;
                        n_state = S_WRITE;
                    end else if (r_idx == LAST) begin
                        n_idx   = '0;
                        n_state = S_EVICT_RD;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_state = S_PROBE_CHK;
                end
            end
            S_PROBE_CHK: begin
                u_req.op = lhc_pkg::OP_EQ;
                u_req.a  = q_key;
                u_req.b  = r_key;
                if (r_used[r_idx] && u_rsp.flag) begin
                    n_found = 1'b1;
                    n_data  = q_data;
                    n_cnt   = q_cnt;
                    n_slot  = r_idx;
                    n_state = S_REPLY;
                end else if (r_idx == LAST) begin
                    n_found = 1'b0;
                    n_state = S_REPLY;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_PROBE_RD;
                end
            end
            S_EVICT_RD: begin
                n_state = S_EVICT_CHK;
            end
            S_EVICT_CHK: begin
                u_req.op = lhc_pkg::OP_LT;
                u_req.a  = lhc_pkg::UNIT_W'(cur_cnt);
                u_req.b  = lhc_pkg::UNIT_W'(r_best_cnt);
                if ((r_idx == '0) || u_rsp.flag) begin
                    n_best_cnt = cur_cnt;
                    n_slot     = r_idx;
                end
                if (r_idx == LAST) begin
                    n_state = S_WRITE;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_EVICT_RD;
                end
            end
            S_WRITE: begin
                mem_addr       = r_slot;
                tbl_we         = 1'b1;
                cnt_we         = 1'b1;
                cnt_wdata      = '0;
                n_used[r_slot] = 1'b1;
                n_state        = S_IDLE;
            end
            S_REPLY: begin
                u_req.op = lhc_pkg::OP_INC;
                u_req.a  = lhc_pkg::UNIT_W'(r_cnt);
                mem_addr = r_slot;
                if (out_load) begin
                    n_out_valid      = 1'b1;
                    n_out.found      = r_found;
                    n_out.read_value = (r_found && (r_req == lhc_pkg::REQ_GET)) ? r_data : '1;
                    cnt_we           = r_found;
                    cnt_wdata        = u_rsp.res[lhc_pkg::CNT_W-1:0];
                    n_state          = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_req      <= n_req;
        r_key      <= n_key;
        r_val      <= n_val;
        r_sum      <= n_sum;
        r_quo      <= n_quo;
        r_idx      <= n_idx;
        r_slot     <= n_slot;
        r_best_cnt <= n_best_cnt;
        r_found    <= n_found;
        r_data     <= n_data;
        r_cnt      <= n_cnt;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_write_sets_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> r_used[$past(r_slot)])
        else $error("slot not marked used after write");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PROBE_RD) || (r_state == S_PROBE_CHK) ||
         (r_state == S_EVICT_RD) || (r_state == S_EVICT_CHK)) |-> (r_idx <= LAST))
        else $error("probe index beyond last slot");

    a_fold_no_borrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (quo_prod <= r_sum))
        else $error("hash quotient too large");

    a_put_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPLY) |-> (r_req != lhc_pkg::REQ_PUT))
        else $error("put reached reply");

    a_reply_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REPLY) && out_load) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("reply did not present a transaction");

endmodule

/* sv/lhc_ram.sv */
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module lhc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/lhc_unit.sv */
// Shared subtract/compare unit: modulo step, equality, less-than, saturating increment.
`timescale 1ns / 1ps

module lhc_unit (
    input  lhc_pkg::t_unit_req i_req,
    output lhc_pkg::t_unit_rsp o_rsp
);

    logic [lhc_pkg::UNIT_W:0] diff;

    assign diff = {1'b0, i_req.a} - {1'b0, i_req.b};

    always_comb begin
        o_rsp.res  = i_req.a;
        o_rsp.flag = 1'b0;
        unique case (i_req.op)
            lhc_pkg::OP_MOD: begin
                o_rsp.res = diff[lhc_pkg::UNIT_W] ? i_req.a : diff[lhc_pkg::UNIT_W-1:0];
            end
            lhc_pkg::OP_EQ: begin
                o_rsp.flag = (diff[lhc_pkg::UNIT_W-1:0] == '0);
            end
            lhc_pkg::OP_LT: begin
                o_rsp.flag = diff[lhc_pkg::UNIT_W];
            end
            lhc_pkg::OP_INC: begin
                o_rsp.res = (i_req.a == lhc_pkg::UNIT_W'(lhc_pkg::COUNT_MAX)) ? i_req.a
                          : i_req.a + lhc_pkg::UNIT_W'(1);
            end
        endcase
    end

endmodule

/* verif/lfu_hash_cache_test.sv */
// Self-checking testbench for the LFU hash cache: directed and random put/get/test traffic.
`timescale 1ns / 1ps

module lfu_hash_cache_test;

    localparam int          SLOT_N      = lhc_pkg::SLOTS_DEF;
    localparam int          POOL_N      = 24;
    localparam int          BLOCK_N     = 7;
    localparam int          BLOCK_ITEMS = 250;
    localparam int          MAX_WAIT    = 18;
    localparam int          HOLD_CYCLES = 600;
    localparam int          TAIL_CYCLES = 100;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [1:0]  REQ_BAD     = 2'd3;

    class lfu_scoreboard;
        logic [lhc_pkg::KEY_W-1:0]        slot_key [SLOT_N];
        logic signed [lhc_pkg::VAL_W-1:0] slot_val [SLOT_N];
        bit                               slot_full[SLOT_N];
        logic [lhc_pkg::CNT_W-1:0]        use_cnt  [SLOT_N];
        lhc_pkg::t_out_item               replies[$];
        int errors;
        int n_puts;
        int n_evicts;
        int n_lookups;
        int n_hits;
        int n_ignored;

        function new();
            for (int i = 0; i < SLOT_N; i++) begin
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_full[i] = 1'b0;
                use_cnt[i]   = '0;
            end
        endfunction

        // Advance the cache image by one accepted transaction.
        function void note_request(lhc_pkg::t_in_item item);
            logic [lhc_pkg::KEY_W-1:0] k;
            int                        sum;
            int                        h;
            int                        s;
            int                        b;
            bit                        ended;
            lhc_pkg::t_out_item        rep;
            k     = '0;
            sum   = 0;
            ended = 1'b0;
            for (b = 0; b < 8; b++) begin
                if (item.key[8*b +: 8] == 8'd0)
                    ended = 1'b1;
                if (!ended) begin
                    k[8*b +: 8] = item.key[8*b +: 8];
                    sum += item.key[8*b +: 8];
                end
            end
            h = sum % SLOT_N;
            s = -1;
            case (item.req_type)
                lhc_pkg::REQ_PUT: begin
                    n_puts++;
                    for (int i = h; i < SLOT_N; i++) begin
                        if (s < 0 && !slot_full[i])
                            s = i;
                    end
                    if (s < 0) begin
                        s = 0;
                        for (int i = 1; i < SLOT_N; i++) begin
                            if (use_cnt[i] < use_cnt[s])
                                s = i;
                        end
                        use_cnt[s] = '0;
                        n_evicts++;
                    end
                    slot_key[s]  = k;
                    slot_val[s]  = item.store_value;
                    slot_full[s] = 1'b1;
                end
                lhc_pkg::REQ_GET, lhc_pkg::REQ_HAS: begin
                    n_lookups++;
                    for (int i = h; i < SLOT_N; i++) begin
                        if (s < 0 && slot_full[i] && slot_key[i] == k)
                            s = i;
                    end
                    rep.found      = (s >= 0);
                    rep.read_value = -1;
                    if (s >= 0) begin
                        n_hits++;
                        if (use_cnt[s] != lhc_pkg::COUNT_MAX)
                            use_cnt[s] = use_cnt[s] + 1'b1;
                        if (item.req_type == lhc_pkg::REQ_GET)
                            rep.read_value = slot_val[s];
                    end
                    replies.push_back(rep);
                end
                default: begin
                    n_ignored++;
                end
            endcase
        endfunction

        function void check_reply(lhc_pkg::t_out_item got);
            lhc_pkg::t_out_item want;
            if (replies.size() == 0) begin
                $error("unexpected result: found %0d read_value %0d", got.found, got.read_value);
                errors++;
                return;
            end
            want = replies.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.read_value !== want.read_value) begin
                $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
                errors++;
            end
        endfunction

        function int pending();
            return replies.size();
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    lhc_pkg::t_in_item  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    lhc_pkg::t_out_item out_data;

    lfu_scoreboard             book;
    logic [lhc_pkg::KEY_W-1:0] key_pool[POOL_N];
    bit                        tx_idle = 1'b0;
    bit                        rx_idle = 1'b0;
    int                        rx_hold = 0;

    lfu_hash_cache dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    function automatic logic [lhc_pkg::KEY_W-1:0] fresh_key();
        logic [lhc_pkg::KEY_W-1:0] k;
        int                        len;
        k   = '0;
        len = ($urandom_range(0, 3) == 0) ? 8 : $urandom_range(0, 7);
        for (int b = 0; b < len; b++)
            k[8*b +: 8] = $urandom_range(1, 255);
        return k;
    endfunction

    function automatic lhc_pkg::t_in_item make_req(logic [1:0] kind,
                                                   logic [lhc_pkg::KEY_W-1:0] key,
                                                   logic [lhc_pkg::VAL_W-1:0] value);
        lhc_pkg::t_in_item item;
        item.req_type    = kind;
        item.key         = key;
        item.store_value = value;
        return item;
    endfunction

    function automatic lhc_pkg::t_in_item rand_req();
        lhc_pkg::t_in_item         item;
        int                        pick;
        int                        len;
        logic [lhc_pkg::KEY_W-1:0] k;
        logic [lhc_pkg::KEY_W-1:0] junk;
        pick = $urandom_range(0, 99);
        junk = {$urandom, $urandom};
        if (pick < 40)
            item.req_type = lhc_pkg::REQ_PUT;
        else if (pick < 70)
            item.req_type = lhc_pkg::REQ_GET;
        else if (pick < 96)
            item.req_type = lhc_pkg::REQ_HAS;
        else
            item.req_type = REQ_BAD;
        if ($urandom_range(0, 9) < 8) begin
            k   = key_pool[$urandom_range(0, POOL_N - 1)];
            len = 0;
            while (len < 8 && k[8*len +: 8] != 8'd0)
                len++;
            // pad with junk past the terminator
            if (len < 7 && $urandom_range(0, 3) == 0)
                k = k | (junk << (8 * (len + 1)));
        end else begin
            k = junk;
        end
        item.key         = k;
        item.store_value = $urandom;
        if ($urandom_range(0, 29) == 0)
            key_pool[$urandom_range(0, POOL_N - 1)] = fresh_key();
        return item;
    endfunction

    task automatic send_item(input lhc_pkg::t_in_item item);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_request(item);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(make_req(lhc_pkg::REQ_PUT, 64'h0, 32'h0));
        send_item(make_req(lhc_pkg::REQ_GET, 64'h0, 32'h0));
        send_item(make_req(lhc_pkg::REQ_HAS, 64'h0, 32'h0));
        send_item(make_req(lhc_pkg::REQ_PUT, 64'h0000_0000_0063_6261, 32'h7FFF_FFFF));
        send_item(make_req(lhc_pkg::REQ_GET, 64'hDEAD_BEEF_0063_6261, 32'h0));
        send_item(make_req(lhc_pkg::REQ_HAS, 64'h1200_0000_0063_6261, 32'h0));
        send_item(make_req(lhc_pkg::REQ_PUT, 64'h0000_0000_0063_6261, 32'h8000_0000));
        send_item(make_req(lhc_pkg::REQ_GET, 64'h0000_0000_0063_6261, 32'hFFFF_FFFF));
        send_item(make_req(lhc_pkg::REQ_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_req(lhc_pkg::REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
        send_item(make_req(lhc_pkg::REQ_PUT, 64'h0000_0000_0000_0080, 32'h8000_0000));
        send_item(make_req(lhc_pkg::REQ_GET, 64'h0000_0000_0000_0080, 32'h0));
        send_item(make_req(lhc_pkg::REQ_PUT, 64'h4847_4645_4443_4241, 32'h1234_5678));
        send_item(make_req(lhc_pkg::REQ_HAS, 64'h4847_4645_4443_4241, 32'h0));
        send_item(make_req(REQ_BAD, 64'h0000_0000_0000_5A5A, 32'h1));
        send_item(make_req(lhc_pkg::REQ_GET, 64'h0000_0000_0000_5A5A, 32'h0));
        send_item(make_req(lhc_pkg::REQ_GET, 64'h0000_0000_00FF_0000, 32'h0));
        send_item(make_req(lhc_pkg::REQ_HAS, 64'h0000_0000_0000_7A79, 32'h0));
        send_item(make_req(REQ_BAD, 64'h0, 32'hFFFF_FFFF));
        send_item(make_req(lhc_pkg::REQ_GET, 64'h4847_4645_4443_4241, 32'h0));
    endtask

    initial begin : reply_sink
        int n;
        wait (rst_n);
        forever begin
            n = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (rx_hold > 0) begin
                n       = rx_hold;
                rx_hold = 0;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            book.check_reply(out_data);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        book = new();
        for (int i = 0; i < POOL_N; i++)
            key_pool[i] = fresh_key();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_directed();
        drain_replies();
        for (int blk = 0; blk < BLOCK_N; blk++) begin
            case (blk)
                0, 4:    begin tx_idle = 1'b0; rx_idle = 1'b0; end
                2:       begin tx_idle = 1'b0; rx_idle = 1'b1; rx_hold = HOLD_CYCLES; end
                5:       begin tx_idle = 1'b1; rx_idle = 1'b0; end
                6:       begin tx_idle = 1'b0; rx_idle = 1'b1; end
                default: begin tx_idle = 1'b1; rx_idle = 1'b1; end
            endcase
            for (int i = 0; i < BLOCK_ITEMS; i++)
                send_item(rand_req());
            drain_replies();
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d puts (%0d evictions), %0d lookups (%0d hits), %0d ignored requests,",
                 book.n_puts, book.n_evicts, book.n_lookups, book.n_hits, book.n_ignored);
        $display("with random gaps on both sides, a long output hold-off and full drains.");
        if (book.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
